// ----- src/mwve_pkg.sv -----
// Shared types, constants and the saturation function of the mecanum wheel velocity estimator.
package mwve_pkg;

  localparam int WHEEL_COUNT = 4;

  // Field and datapath widths.
  localparam int TICK_W  = 32;
  localparam int GAIN_W  = 32;
  localparam int SUM_W   = 34;
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 26;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int GS_W    = 2 * MUL_B_W;
  localparam int NUM_W   = SUM_W + GS_W;
  localparam int DEN_SH  = 8;
  localparam int DEN_W   = TICK_W + DEN_SH;
  localparam int Q_W     = 32;
  localparam int HI_W    = NUM_W - Q_W;

  // Microseconds per second, the scale applied to each gain.
  localparam logic [MUL_B_W-1:0] US_SCALE = MUL_B_W'(1000000);

  // Saturation limits of a Q16.16 result.
  localparam logic [Q_W-1:0] POS_CAP = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] NEG_CAP = 32'h8000_0000;

  // Sequencing counts.
  localparam int CNT_W     = 5;
  localparam int MUL_OPS   = 6;
  localparam int DIV_STEPS = 32;

  // Multiplier operations, in the order the controller issues them.
  localparam int OP_W = 3;
  typedef logic [OP_W-1:0] mul_op_t;
  localparam mul_op_t OP_GA    = 3'd0;
  localparam mul_op_t OP_GL    = 3'd1;
  localparam mul_op_t OP_NA_LO = 3'd2;
  localparam mul_op_t OP_NA_HI = 3'd3;
  localparam mul_op_t OP_NL_LO = 3'd4;
  localparam mul_op_t OP_NL_HI = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_in;
    logic    form_sum;
    logic    form_mag;
    logic    mul_en;
    mul_op_t mul_op;
    logic    acc_en;
    mul_op_t acc_op;
    logic    div_init;
    logic    div_step;
    logic    load_out;
  } mwve_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic zero;
    logic out_free;
  } mwve_sts_t;

  // Applies the sign to a quotient magnitude and saturates it to 32 bits signed.
  function automatic logic [Q_W-1:0] sat_rate(input logic ovf, input logic [Q_W-1:0] q,
                                              input logic neg);
    logic [Q_W-1:0] r;
    if (neg) begin
      if (ovf || (q > NEG_CAP)) r = NEG_CAP;
      else r = (~q) + Q_W'(1);
    end else begin
      if (ovf || (q > POS_CAP)) r = POS_CAP;
      else r = q;
    end
    return r;
  endfunction

endpackage

// ----- src/mecanum_wheel_velocity_estimator_top.sv -----
// Top level of the mecanum wheel velocity estimator.
//
// Input channel (in_valid/in_ready): one item carries four absolute encoder
// counts and the microseconds since the previous item. Output channel
// (out_valid/out_ready): one item with yaw rate and x/y speed in Q16.16,
// saturated, and a flag for a zero elapsed time (speeds then zero).
// The user must write the gains over the APB-style port only while the block
// is idle; the block itself does not enforce it. The block takes one item at
// a time and is ready again the cycle after its result is loaded. The 32-step
// restoring divider follows the products formed on the one shared 34x26
// multiplier; when the elapsed time is zero the block skips both.
// Reset clears the gains, the stored previous counts and the output valid.
// A stalled receiver leaves the result in the output register; the block may
// take and work the next item meanwhile and then waits before loading it.
module mecanum_wheel_velocity_estimator_top import mwve_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [TICK_W-1:0] in_tick_front_left,
  input  logic [TICK_W-1:0] in_tick_front_right,
  input  logic [TICK_W-1:0] in_tick_rear_left,
  input  logic [TICK_W-1:0] in_tick_rear_right,
  input  logic [TICK_W-1:0] in_elapsed_us,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [Q_W-1:0]    out_angular_z,
  output logic [Q_W-1:0]    out_linear_x,
  output logic [Q_W-1:0]    out_linear_y,
  output logic              out_time_error,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [GAIN_W-1:0]                  linear_gain;
  logic [GAIN_W-1:0]                  angular_gain;
  logic [WHEEL_COUNT-1:0][TICK_W-1:0] tick;
  mwve_cmd_t                          cmd;
  mwve_sts_t                          sts;

  // Wheel order: front left, front right, rear left, rear right.
  assign tick = {in_tick_rear_right, in_tick_rear_left, in_tick_front_right,
                 in_tick_front_left};

  mwve_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .linear_gain  (linear_gain),
    .angular_gain (angular_gain)
  );

  mwve_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mwve_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .tick           (tick),
    .elapsed_us     (in_elapsed_us),
    .linear_gain    (linear_gain),
    .angular_gain   (angular_gain),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_angular_z  (out_angular_z),
    .out_linear_x   (out_linear_x),
    .out_linear_y   (out_linear_y),
    .out_time_error (out_time_error)
  );

endmodule

// ----- src/mwve_regs.sv -----
// Configuration registers with the APB-style access port.
module mwve_regs import mwve_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [GAIN_W-1:0] linear_gain,
  output logic [GAIN_W-1:0] angular_gain
);

  localparam logic REG_LINEAR  = 1'b0;
  localparam logic REG_ANGULAR = 1'b1;

  logic [GAIN_W-1:0] lin_gain_r;
  logic [GAIN_W-1:0] ang_gain_r;
  logic              wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes at the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_gain_r <= '0;
      ang_gain_r <= '0;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_LINEAR:  lin_gain_r <= pwdata;
        REG_ANGULAR: ang_gain_r <= pwdata;
        default:     lin_gain_r <= lin_gain_r;
      endcase
    end
  end

  // Read back.
  assign prdata = (paddr[2] == REG_ANGULAR) ? ang_gain_r : lin_gain_r;

  assign linear_gain  = lin_gain_r;
  assign angular_gain = ang_gain_r;

endmodule

// ----- src/mwve_ctrl.sv -----
// Controller state machine that sequences the sum, multiply and divide steps.
module mwve_ctrl import mwve_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  mwve_sts_t sts,
  output mwve_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SUM  = 3'd1;
  localparam logic [2:0] ST_ABS  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_CHK  = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0]       state_r;
  logic [2:0]       state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  assign in_ready = (state_r == ST_IDLE);

  // Next state, step counter and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.form_sum = 1'b1;
        state_nxt    = sts.zero ? ST_DONE : ST_ABS;
      end
      ST_ABS: begin
        cmd.form_mag = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_MUL;
      end
      ST_MUL: begin
        // Issue one product per cycle and fold in the one from the cycle before.
        cmd.mul_en = (cnt_r < CNT_W'(MUL_OPS));
        cmd.mul_op = cnt_r[OP_W-1:0];
        cmd.acc_en = (cnt_r != '0);
        cmd.acc_op = cnt_r[OP_W-1:0] - OP_W'(1);
        if (cnt_r == CNT_W'(MUL_OPS)) begin
          state_nxt = ST_CHK;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_CHK: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ----- src/mwve_dp.sv -----
// Datapath: tick deltas, shared multiplier, two-lane restoring divider and output register.
module mwve_dp import mwve_pkg::*; (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [WHEEL_COUNT-1:0][TICK_W-1:0] tick,
  input  logic [TICK_W-1:0]                 elapsed_us,
  input  logic [GAIN_W-1:0]                 linear_gain,
  input  logic [GAIN_W-1:0]                 angular_gain,
  input  mwve_cmd_t                         cmd,
  output mwve_sts_t                         sts,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [Q_W-1:0]                    out_angular_z,
  output logic [Q_W-1:0]                    out_linear_x,
  output logic [Q_W-1:0]                    out_linear_y,
  output logic                              out_time_error
);

  localparam int FL = 0;
  localparam int FR = 1;
  localparam int RL = 2;
  localparam int RR = 3;

  logic [WHEEL_COUNT-1:0][TICK_W-1:0] prev_r;
  logic [WHEEL_COUNT-1:0][TICK_W-1:0] delta_r;
  logic [WHEEL_COUNT-1:0][SUM_W-1:0]  dx;
  logic [TICK_W-1:0]                  us_r;
  logic                               zero_r;
  logic [SUM_W-1:0]                   sum_a_r;
  logic [SUM_W-1:0]                   sum_l_r;
  logic [SUM_W-1:0]                   mag_a_r;
  logic [SUM_W-1:0]                   mag_l_r;
  logic                               neg_a_r;
  logic                               neg_l_r;
  logic [MUL_A_W-1:0]                 mul_a;
  logic [MUL_B_W-1:0]                 mul_b;
  logic [PROD_W-1:0]                  prod_nxt;
  logic [PROD_W-1:0]                  prod_r;
  logic [GS_W-1:0]                    g_a_r;
  logic [GS_W-1:0]                    g_l_r;
  logic [NUM_W-1:0]                   num_a_r;
  logic [NUM_W-1:0]                   num_l_r;
  logic [DEN_W-1:0]                   den;
  logic [HI_W-1:0]                    hi_a;
  logic [HI_W-1:0]                    hi_l;
  logic [DEN_W-1:0]                   rem_a_r;
  logic [DEN_W-1:0]                   rem_l_r;
  logic [Q_W-1:0]                     lo_a_r;
  logic [Q_W-1:0]                     lo_l_r;
  logic [Q_W-1:0]                     q_a_r;
  logic [Q_W-1:0]                     q_l_r;
  logic                               ovf_a_r;
  logic                               ovf_l_r;
  logic [DEN_W:0]                     t_a;
  logic [DEN_W:0]                     t_l;
  logic [DEN_W:0]                     d_a;
  logic [DEN_W:0]                     d_l;
  logic                               ge_a;
  logic                               ge_l;
  logic                               out_valid_r;
  logic [Q_W-1:0]                     ang_r;
  logic [Q_W-1:0]                     linx_r;
  logic [Q_W-1:0]                     liny_r;
  logic                               err_r;

  // Previous counts are kept from one item to the next.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (cmd.load_in) begin
      prev_r <= tick;
    end
  end

  // Sign-extended deltas.
  always_comb begin
    for (int i = 0; i < WHEEL_COUNT; i++) begin
      dx[i] = {{(SUM_W - TICK_W){delta_r[i][TICK_W-1]}}, delta_r[i]};
    end
  end

  assign den = {us_r, {DEN_SH{1'b0}}};

  // Wrap-around deltas, wheel sums and their magnitudes.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      for (int i = 0; i < WHEEL_COUNT; i++) begin
        delta_r[i] <= tick[i] - prev_r[i];
      end
      us_r   <= elapsed_us;
      zero_r <= (elapsed_us == '0);
    end
    if (cmd.form_sum) begin
      sum_a_r <= dx[FR] + dx[RR] - dx[FL] - dx[RL];
      sum_l_r <= dx[FL] + dx[FR] + dx[RL] + dx[RR];
    end
    if (cmd.form_mag) begin
      neg_a_r <= sum_a_r[SUM_W-1];
      neg_l_r <= sum_l_r[SUM_W-1];
      mag_a_r <= sum_a_r[SUM_W-1] ? ((~sum_a_r) + SUM_W'(1)) : sum_a_r;
      mag_l_r <= sum_l_r[SUM_W-1] ? ((~sum_l_r) + SUM_W'(1)) : sum_l_r;
    end
  end

  // Shared multiplier operand selection.
  always_comb begin
    unique case (cmd.mul_op)
      OP_GA: begin
        mul_a = MUL_A_W'(angular_gain);
        mul_b = US_SCALE;
      end
      OP_GL: begin
        mul_a = MUL_A_W'(linear_gain);
        mul_b = US_SCALE;
      end
      OP_NA_LO: begin
        mul_a = mag_a_r;
        mul_b = g_a_r[MUL_B_W-1:0];
      end
      OP_NA_HI: begin
        mul_a = mag_a_r;
        mul_b = g_a_r[GS_W-1:MUL_B_W];
      end
      OP_NL_LO: begin
        mul_a = mag_l_r;
        mul_b = g_l_r[MUL_B_W-1:0];
      end
      OP_NL_HI: begin
        mul_a = mag_l_r;
        mul_b = g_l_r[GS_W-1:MUL_B_W];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // Product register and accumulation of the partial products.
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd.acc_en) begin
      unique case (cmd.acc_op)
        OP_GA:    g_a_r   <= prod_r[GS_W-1:0];
        OP_GL:    g_l_r   <= prod_r[GS_W-1:0];
        OP_NA_LO: num_a_r <= NUM_W'(prod_r);
        OP_NA_HI: num_a_r <= num_a_r + {prod_r, {MUL_B_W{1'b0}}};
        OP_NL_LO: num_l_r <= NUM_W'(prod_r);
        OP_NL_HI: num_l_r <= num_l_r + {prod_r, {MUL_B_W{1'b0}}};
        default:  g_a_r   <= g_a_r;
      endcase
    end
  end

  // Divider: the high part of the numerator seeds the remainder, one quotient bit a step.
  assign hi_a = num_a_r[NUM_W-1:Q_W];
  assign hi_l = num_l_r[NUM_W-1:Q_W];
  assign t_a  = {rem_a_r, lo_a_r[Q_W-1]};
  assign t_l  = {rem_l_r, lo_l_r[Q_W-1]};
  assign ge_a = (t_a >= {1'b0, den});
  assign ge_l = (t_l >= {1'b0, den});
  assign d_a  = t_a - {1'b0, den};
  assign d_l  = t_l - {1'b0, den};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      ovf_a_r <= (hi_a >= HI_W'(den));
      ovf_l_r <= (hi_l >= HI_W'(den));
      rem_a_r <= hi_a[DEN_W-1:0];
      rem_l_r <= hi_l[DEN_W-1:0];
      lo_a_r  <= num_a_r[Q_W-1:0];
      lo_l_r  <= num_l_r[Q_W-1:0];
      q_a_r   <= '0;
      q_l_r   <= '0;
    end else if (cmd.div_step) begin
      rem_a_r <= ge_a ? d_a[DEN_W-1:0] : t_a[DEN_W-1:0];
      rem_l_r <= ge_l ? d_l[DEN_W-1:0] : t_l[DEN_W-1:0];
      lo_a_r  <= {lo_a_r[Q_W-2:0], 1'b0};
      lo_l_r  <= {lo_l_r[Q_W-2:0], 1'b0};
      q_a_r   <= {q_a_r[Q_W-2:0], ge_a};
      q_l_r   <= {q_l_r[Q_W-2:0], ge_l};
    end
  end

  // Output register: holds a finished item until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (zero_r) begin
        ang_r  <= '0;
        linx_r <= '0;
        liny_r <= '0;
        err_r  <= 1'b1;
      end else begin
        ang_r  <= sat_rate(ovf_a_r, q_a_r, neg_a_r);
        linx_r <= sat_rate(ovf_l_r, q_l_r, neg_l_r);
        liny_r <= sat_rate(ovf_l_r, q_l_r, !neg_l_r);
        err_r  <= 1'b0;
      end
    end
  end

  assign sts.zero     = zero_r;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_angular_z  = ang_r;
  assign out_linear_x   = linx_r;
  assign out_linear_y   = liny_r;
  assign out_time_error = err_r;

endmodule
